FILE: hw/rtl/qdi_pkg.sv
// ----------------------------------------------------------------------------
// qdi_pkg
// Shared types, constants and helpers of the quadratic demand interpolator.
// ----------------------------------------------------------------------------
package qdi_pkg;

  // Axis count and coefficient format
  localparam int AXES            = 7;
  localparam int COEFF_FRAC_BITS = 48;
  localparam int SCALE_SHIFT     = COEFF_FRAC_BITS - 16;
  localparam int INPUT_AXES      = 7;
  localparam int AX_W            = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int POS_IDX_W       = $clog2(INPUT_AXES);

  // Field widths
  localparam int TIME_W  = 40;
  localparam int POS_W   = 32;
  localparam int COEFF_W = 64;

  // Time differences (t1, t2, t1-t2, query dt) fit in TIME_W+2 signed bits
  localparam int DIFF_W  = TIME_W + 2;
  localparam int MUL_B_W = DIFF_W;

  // Working width: holds the scaled linear numerator and the query sum
  localparam int WORK_W = (SCALE_SHIFT > 32) ? 118 + SCALE_SHIFT : 150;
  localparam int CNT_W  = $clog2(WORK_W + 1);

  typedef logic signed [WORK_W-1:0]  qdi_work_t;
  typedef logic signed [DIFF_W-1:0]  qdi_diff_t;
  typedef logic signed [COEFF_W-1:0] qdi_coeff_t;
  typedef logic signed [POS_W-1:0]   qdi_pos_t;

  // Rounding addend for truncation toward zero of negative sums
  localparam qdi_work_t RND_ADD = (qdi_work_t'(1) <<< SCALE_SHIFT) - qdi_work_t'(1);

  typedef enum logic {
    OP_DEMAND = 1'b0,
    OP_QUERY  = 1'b1
  } qdi_op_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_AXIS_RANGE = 2'd1,
    STS_ZERO_DEN   = 2'd2
  } qdi_status_e;

  typedef struct packed {
    qdi_op_e           operation;
    logic [TIME_W-1:0] time_us;
    qdi_pos_t          pos_tilt_ax;
    qdi_pos_t          pos_tilt_ay;
    qdi_pos_t          pos_tilt_bx;
    qdi_pos_t          pos_tilt_by;
    qdi_pos_t          pos_tilt_cx;
    qdi_pos_t          pos_tilt_cy;
    qdi_pos_t          pos_focus;
    logic [2:0]        query_axis;
  } qdi_in_t;

  typedef struct packed {
    qdi_pos_t    estimate;
    qdi_status_e status;
  } qdi_out_t;

  // Shared multiply / divide unit
  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } qdi_alu_op_e;

  typedef struct packed {
    logic        start;
    qdi_alu_op_e op;
  } qdi_alu_cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL,
    PH_ABSN,
    PH_ABSD,
    PH_DIV,
    PH_SIGN
  } qdi_alu_ph_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_T1S,
    ST_T2S,
    ST_P12,
    ST_DEN,
    ST_NA0,
    ST_NA1,
    ST_NA2,
    ST_DIVA,
    ST_NB0,
    ST_NB1,
    ST_DIVB,
    ST_WRITE,
    ST_Q0,
    ST_Q1,
    ST_QRND,
    ST_QFIN,
    ST_OUT
  } qdi_state_e;

  // Saturate a working value to a signed coefficient
  function automatic qdi_coeff_t sat_coeff(input qdi_work_t v);
    logic [WORK_W-COEFF_W:0] hi;
    hi = v[WORK_W-1:COEFF_W-1];
    if (hi == {(WORK_W-COEFF_W+1){v[WORK_W-1]}}) begin
      return qdi_coeff_t'(v[COEFF_W-1:0]);
    end else if (v[WORK_W-1]) begin
      return {1'b1, {(COEFF_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COEFF_W-1){1'b1}}};
    end
  endfunction

  // Saturate a working value to a signed Q15.16 position
  function automatic qdi_pos_t sat_pos(input qdi_work_t v);
    logic [WORK_W-POS_W:0] hi;
    hi = v[WORK_W-1:POS_W-1];
    if (hi == {(WORK_W-POS_W+1){v[WORK_W-1]}}) begin
      return qdi_pos_t'(v[POS_W-1:0]);
    end else if (v[WORK_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: hw/rtl/qdi_stream_if.sv
// ----------------------------------------------------------------------------
// qdi_stream_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface qdi_in_if;
  logic            valid;
  logic            ready;
  qdi_pkg::qdi_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qdi_out_if;
  logic             valid;
  logic             ready;
  qdi_pkg::qdi_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/qdi_muldiv.sv
// ----------------------------------------------------------------------------
// qdi_muldiv
// Bit-serial multiply-accumulate and restoring divide around one wide adder.
// ----------------------------------------------------------------------------
module qdi_muldiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qdi_pkg::qdi_alu_cmd_t cmd_i,
  input  qdi_pkg::qdi_work_t   acc_i,
  input  qdi_pkg::qdi_work_t   opa_i,
  input  qdi_pkg::qdi_work_t   opb_i,
  output logic                 done_o,
  output qdi_pkg::qdi_work_t   res_o
);

  localparam int W  = qdi_pkg::WORK_W;
  localparam int MB = qdi_pkg::MUL_B_W;

  qdi_pkg::qdi_alu_ph_e     ph_q, ph_d;
  logic [qdi_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      done_q, done_d;

  qdi_pkg::qdi_work_t acc_q, a_q, quo_q, rem_q;
  logic [MB-1:0]      b_q, b_mag;
  logic               neg_q;

  qdi_pkg::qdi_work_t add_x, add_y, sum, rem_sh;
  logic               add_sub;
  logic               last;

  assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
  assign b_mag  = opb_i[MB-1] ? (~opb_i[MB-1:0] + MB'(1)) : opb_i[MB-1:0];

  // Select the operands of the shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (ph_q)
      qdi_pkg::PH_MUL: begin
        add_x   = acc_q;
        add_y   = a_q;
        add_sub = neg_q;
      end
      qdi_pkg::PH_ABSN: begin
        add_y   = quo_q;
        add_sub = 1'b1;
      end
      qdi_pkg::PH_ABSD: begin
        add_y   = a_q;
        add_sub = 1'b1;
      end
      qdi_pkg::PH_DIV: begin
        add_x   = rem_sh;
        add_y   = a_q;
        add_sub = 1'b1;
      end
      qdi_pkg::PH_SIGN: begin
        add_y   = quo_q;
        add_sub = neg_q;
      end
      default: begin
      end
    endcase
  end

  assign sum = add_x + (add_y ^ {W{add_sub}}) + W'(add_sub);

  // Phase sequencing
  always_comb begin
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    last   = 1'b0;
    unique case (ph_q)
      qdi_pkg::PH_IDLE: begin
        if (cmd_i.start) begin
          cnt_d = '0;
          ph_d  = (cmd_i.op == qdi_pkg::ALU_MUL) ? qdi_pkg::PH_MUL : qdi_pkg::PH_ABSN;
        end
      end
      qdi_pkg::PH_MUL: begin
        last  = (cnt_q == qdi_pkg::CNT_W'(MB - 1));
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          ph_d   = qdi_pkg::PH_IDLE;
          done_d = 1'b1;
        end
      end
      qdi_pkg::PH_ABSN: ph_d = qdi_pkg::PH_ABSD;
      qdi_pkg::PH_ABSD: begin
        ph_d  = qdi_pkg::PH_DIV;
        cnt_d = '0;
      end
      qdi_pkg::PH_DIV: begin
        last  = (cnt_q == qdi_pkg::CNT_W'(W - 1));
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          ph_d = qdi_pkg::PH_SIGN;
        end
      end
      qdi_pkg::PH_SIGN: begin
        ph_d   = qdi_pkg::PH_IDLE;
        done_d = 1'b1;
      end
      default: ph_d = qdi_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= qdi_pkg::PH_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    unique case (ph_q)
      qdi_pkg::PH_IDLE: begin
        if (cmd_i.start) begin
          if (cmd_i.op == qdi_pkg::ALU_MUL) begin
            acc_q <= acc_i;
            a_q   <= opa_i;
            b_q   <= b_mag;
            neg_q <= opb_i[MB-1];
          end else begin
            quo_q <= opa_i;
            a_q   <= opb_i;
            rem_q <= '0;
            neg_q <= opa_i[W-1] ^ opb_i[W-1];
          end
        end
      end
      qdi_pkg::PH_MUL: begin
        if (b_q[0]) begin
          acc_q <= sum;
        end
        a_q <= a_q <<< 1;
        b_q <= b_q >> 1;
      end
      qdi_pkg::PH_ABSN: begin
        if (quo_q[W-1]) begin
          quo_q <= sum;
        end
      end
      qdi_pkg::PH_ABSD: begin
        if (a_q[W-1]) begin
          a_q <= sum;
        end
      end
      qdi_pkg::PH_DIV: begin
        if (!sum[W-1]) begin
          rem_q <= sum;
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
      end
      qdi_pkg::PH_SIGN: acc_q <= sum;
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

FILE: hw/rtl/quadratic_demand_interpolator_core.sv
// ----------------------------------------------------------------------------
// quadratic_demand_interpolator_core
// Fits a per-axis quadratic through three demand samples and evaluates it
// on query words, using one shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// A demand word runs five products and two quotients on each of the seven axes,
//   plus four shared products; a query word runs three products; zero-denominator
//   and axis errors skip the arithmetic and go straight to the result word.
// Throughput: one word at a time; the serial multiply-divide unit sets it.
// Reset: times, samples and coefficients clear to zero; no word is pending.
module quadratic_demand_interpolator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  qdi_in_if.sink     in_i,
  qdi_out_if.source  out_o
);

  localparam int AX_W = qdi_pkg::AX_W;
  localparam int S    = qdi_pkg::SCALE_SHIFT;

  qdi_pkg::qdi_state_e state_q, state_d;

  // Captured word and history
  qdi_pkg::qdi_in_t          in_q;
  logic [qdi_pkg::TIME_W-1:0] time_oldest_q, time_middle_q, time_datum_q;
  qdi_pkg::qdi_pos_t   sample_oldest_q  [qdi_pkg::AXES];
  qdi_pkg::qdi_pos_t   sample_middle_q  [qdi_pkg::AXES];
  qdi_pkg::qdi_coeff_t coeff_square_q   [qdi_pkg::AXES];
  qdi_pkg::qdi_coeff_t coeff_linear_q   [qdi_pkg::AXES];
  qdi_pkg::qdi_pos_t   coeff_constant_q [qdi_pkg::AXES];

  // Working registers
  qdi_pkg::qdi_diff_t t1_q, t2_q, d12_q, dt_q;
  qdi_pkg::qdi_work_t t1s_q, t2s_q, den_q, tmp_q;
  logic [AX_W-1:0]    ax_q;
  logic               issued_q;
  qdi_pkg::qdi_out_t  res_q;

  // Combinational helpers
  qdi_pkg::qdi_diff_t t1_c, t2_c, d12_c, dt_c;
  logic               zero_den_c, axis_bad_c, is_arith, last_ax;
  logic [AX_W-1:0]    qax;
  qdi_pkg::qdi_pos_t  x0, x1, x2;
  qdi_pkg::qdi_alu_cmd_t alu_cmd;
  qdi_pkg::qdi_work_t alu_acc, alu_opa, alu_opb, alu_res;
  logic               alu_done;

  function automatic qdi_pkg::qdi_pos_t pos_pick(input qdi_pkg::qdi_in_t w,
                                                 input logic [qdi_pkg::POS_IDX_W-1:0] idx);
    qdi_pkg::qdi_pos_t r;
    unique case (idx)
      3'd0:    r = w.pos_tilt_ax;
      3'd1:    r = w.pos_tilt_ay;
      3'd2:    r = w.pos_tilt_bx;
      3'd3:    r = w.pos_tilt_by;
      3'd4:    r = w.pos_tilt_cx;
      3'd5:    r = w.pos_tilt_cy;
      3'd6:    r = w.pos_focus;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Time differences against the oldest and datum times
  assign t1_c  = qdi_pkg::DIFF_W'({1'b0, time_middle_q}) - qdi_pkg::DIFF_W'({1'b0, time_oldest_q});
  assign t2_c  = qdi_pkg::DIFF_W'({1'b0, in_q.time_us}) - qdi_pkg::DIFF_W'({1'b0, time_oldest_q});
  assign d12_c = t1_c - t2_c;
  assign dt_c  = qdi_pkg::DIFF_W'({1'b0, in_q.time_us}) - qdi_pkg::DIFF_W'({1'b0, time_datum_q});
  assign zero_den_c = (t1_c == '0) || (t2_c == '0) || (t1_c == t2_c);
  assign axis_bad_c = (int'(in_q.query_axis) >= qdi_pkg::AXES);
  assign qax        = AX_W'(in_q.query_axis);
  assign last_ax    = (ax_q == AX_W'(qdi_pkg::AXES - 1));

  // Samples of the current axis
  assign x0 = sample_oldest_q[ax_q];
  assign x1 = sample_middle_q[ax_q];
  assign x2 = (int'(ax_q) < qdi_pkg::INPUT_AXES) ?
              pos_pick(in_q, qdi_pkg::POS_IDX_W'(ax_q)) : '0;

  always_comb begin
    unique case (state_q)
      qdi_pkg::ST_T1S, qdi_pkg::ST_T2S, qdi_pkg::ST_P12, qdi_pkg::ST_DEN,
      qdi_pkg::ST_NA0, qdi_pkg::ST_NA1, qdi_pkg::ST_NA2, qdi_pkg::ST_DIVA,
      qdi_pkg::ST_NB0, qdi_pkg::ST_NB1, qdi_pkg::ST_DIVB,
      qdi_pkg::ST_Q0, qdi_pkg::ST_Q1, qdi_pkg::ST_QRND: is_arith = 1'b1;
      default: is_arith = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qdi_pkg::ST_IDLE: if (in_i.valid) state_d = qdi_pkg::ST_CHECK;
      qdi_pkg::ST_CHECK: begin
        if (in_q.operation == qdi_pkg::OP_QUERY) begin
          state_d = axis_bad_c ? qdi_pkg::ST_OUT : qdi_pkg::ST_Q0;
        end else begin
          state_d = zero_den_c ? qdi_pkg::ST_OUT : qdi_pkg::ST_T1S;
        end
      end
      qdi_pkg::ST_T1S:  if (alu_done) state_d = qdi_pkg::ST_T2S;
      qdi_pkg::ST_T2S:  if (alu_done) state_d = qdi_pkg::ST_P12;
      qdi_pkg::ST_P12:  if (alu_done) state_d = qdi_pkg::ST_DEN;
      qdi_pkg::ST_DEN:  if (alu_done) state_d = qdi_pkg::ST_NA0;
      qdi_pkg::ST_NA0:  if (alu_done) state_d = qdi_pkg::ST_NA1;
      qdi_pkg::ST_NA1:  if (alu_done) state_d = qdi_pkg::ST_NA2;
      qdi_pkg::ST_NA2:  if (alu_done) state_d = qdi_pkg::ST_DIVA;
      qdi_pkg::ST_DIVA: if (alu_done) state_d = qdi_pkg::ST_NB0;
      qdi_pkg::ST_NB0:  if (alu_done) state_d = qdi_pkg::ST_NB1;
      qdi_pkg::ST_NB1:  if (alu_done) state_d = qdi_pkg::ST_DIVB;
      qdi_pkg::ST_DIVB: if (alu_done) state_d = qdi_pkg::ST_WRITE;
      qdi_pkg::ST_WRITE: state_d = last_ax ? qdi_pkg::ST_OUT : qdi_pkg::ST_NA0;
      qdi_pkg::ST_Q0:   if (alu_done) state_d = qdi_pkg::ST_Q1;
      qdi_pkg::ST_Q1:   if (alu_done) state_d = qdi_pkg::ST_QRND;
      qdi_pkg::ST_QRND: if (alu_done) state_d = qdi_pkg::ST_QFIN;
      qdi_pkg::ST_QFIN: state_d = qdi_pkg::ST_OUT;
      qdi_pkg::ST_OUT:  if (out_o.ready) state_d = qdi_pkg::ST_IDLE;
      default: state_d = qdi_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshakes and operands of the shared unit
  always_comb begin
    in_i.ready    = (state_q == qdi_pkg::ST_IDLE);
    out_o.valid   = (state_q == qdi_pkg::ST_OUT);
    out_o.data    = res_q;
    alu_cmd.start = is_arith && !issued_q;
    alu_cmd.op    = qdi_pkg::ALU_MUL;
    alu_acc       = '0;
    alu_opa       = '0;
    alu_opb       = '0;
    unique case (state_q)
      qdi_pkg::ST_T1S: begin
        alu_opa = qdi_pkg::qdi_work_t'(t1_q);
        alu_opb = qdi_pkg::qdi_work_t'(t1_q);
      end
      qdi_pkg::ST_T2S: begin
        alu_opa = qdi_pkg::qdi_work_t'(t2_q);
        alu_opb = qdi_pkg::qdi_work_t'(t2_q);
      end
      qdi_pkg::ST_P12: begin
        alu_opa = qdi_pkg::qdi_work_t'(t1_q);
        alu_opb = qdi_pkg::qdi_work_t'(t2_q);
      end
      qdi_pkg::ST_DEN: begin
        alu_opa = tmp_q;
        alu_opb = qdi_pkg::qdi_work_t'(d12_q);
      end
      qdi_pkg::ST_NA0: begin
        alu_opa = qdi_pkg::qdi_work_t'(d12_q);
        alu_opb = qdi_pkg::qdi_work_t'(x0);
      end
      qdi_pkg::ST_NA1: begin
        alu_acc = tmp_q;
        alu_opa = qdi_pkg::qdi_work_t'(t2_q);
        alu_opb = qdi_pkg::qdi_work_t'(x1);
      end
      qdi_pkg::ST_NA2: begin
        alu_acc = tmp_q;
        alu_opa = qdi_pkg::qdi_work_t'(t1_q);
        alu_opb = -qdi_pkg::qdi_work_t'(x2);
      end
      qdi_pkg::ST_DIVA, qdi_pkg::ST_DIVB: begin
        alu_cmd.op = qdi_pkg::ALU_DIV;
        alu_opa    = tmp_q <<< S;
        alu_opb    = den_q;
      end
      qdi_pkg::ST_NB0: begin
        alu_opa = t2s_q;
        alu_opb = qdi_pkg::qdi_work_t'(x0) - qdi_pkg::qdi_work_t'(x1);
      end
      qdi_pkg::ST_NB1: begin
        alu_acc = tmp_q;
        alu_opa = t1s_q;
        alu_opb = qdi_pkg::qdi_work_t'(x2) - qdi_pkg::qdi_work_t'(x0);
      end
      qdi_pkg::ST_Q0: begin
        alu_acc = qdi_pkg::qdi_work_t'(coeff_linear_q[qax]);
        alu_opa = qdi_pkg::qdi_work_t'(coeff_square_q[qax]);
        alu_opb = qdi_pkg::qdi_work_t'(dt_q);
      end
      qdi_pkg::ST_Q1: begin
        alu_acc = qdi_pkg::qdi_work_t'(coeff_constant_q[qax]) <<< S;
        alu_opa = tmp_q;
        alu_opb = qdi_pkg::qdi_work_t'(dt_q);
      end
      qdi_pkg::ST_QRND: begin
        // bias negative sums so the shift rounds toward zero
        alu_acc = tmp_q;
        alu_opa = tmp_q[qdi_pkg::WORK_W-1] ? qdi_pkg::RND_ADD : '0;
        alu_opb = qdi_pkg::qdi_work_t'(1);
      end
      default: begin
      end
    endcase
  end

  qdi_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (alu_cmd),
    .acc_i  (alu_acc),
    .opa_i  (alu_opa),
    .opb_i  (alu_opb),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= qdi_pkg::ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (alu_done) begin
        issued_q <= 1'b0;
      end else if (alu_cmd.start) begin
        issued_q <= 1'b1;
      end
    end
  end

  // History: times, samples and coefficients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_oldest_q <= '0;
      time_middle_q <= '0;
      time_datum_q  <= '0;
      for (int i = 0; i < qdi_pkg::AXES; i++) begin
        sample_oldest_q[i]  <= '0;
        sample_middle_q[i]  <= '0;
        coeff_square_q[i]   <= '0;
        coeff_linear_q[i]   <= '0;
        coeff_constant_q[i] <= '0;
      end
    end else begin
      // shift times on every demand, even with a zero denominator
      if (state_q == qdi_pkg::ST_CHECK && in_q.operation == qdi_pkg::OP_DEMAND) begin
        time_datum_q  <= time_oldest_q;
        time_oldest_q <= time_middle_q;
        time_middle_q <= in_q.time_us;
      end
      if (state_q == qdi_pkg::ST_DIVA && alu_done) begin
        coeff_square_q[ax_q] <= qdi_pkg::sat_coeff(alu_res);
      end
      if (state_q == qdi_pkg::ST_DIVB && alu_done) begin
        coeff_linear_q[ax_q] <= qdi_pkg::sat_coeff(alu_res);
      end
      if (state_q == qdi_pkg::ST_WRITE) begin
        coeff_constant_q[ax_q] <= x0;
        sample_oldest_q[ax_q]  <= x1;
        sample_middle_q[ax_q]  <= x2;
      end
    end
  end

  // Working registers and result word
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    unique case (state_q)
      qdi_pkg::ST_CHECK: begin
        t1_q           <= t1_c;
        t2_q           <= t2_c;
        d12_q          <= d12_c;
        dt_q           <= dt_c;
        ax_q           <= '0;
        res_q.estimate <= '0;
        if (in_q.operation == qdi_pkg::OP_QUERY) begin
          res_q.status <= axis_bad_c ? qdi_pkg::STS_AXIS_RANGE : qdi_pkg::STS_OK;
        end else begin
          res_q.status <= zero_den_c ? qdi_pkg::STS_ZERO_DEN : qdi_pkg::STS_OK;
        end
      end
      qdi_pkg::ST_T1S: if (alu_done) t1s_q <= alu_res;
      qdi_pkg::ST_T2S: if (alu_done) t2s_q <= alu_res;
      qdi_pkg::ST_DEN: if (alu_done) den_q <= alu_res;
      qdi_pkg::ST_P12, qdi_pkg::ST_NA0, qdi_pkg::ST_NA1, qdi_pkg::ST_NA2,
      qdi_pkg::ST_NB0, qdi_pkg::ST_NB1, qdi_pkg::ST_Q0, qdi_pkg::ST_Q1,
      qdi_pkg::ST_QRND: if (alu_done) tmp_q <= alu_res;
      qdi_pkg::ST_WRITE: ax_q <= ax_q + 1'b1;
      qdi_pkg::ST_QFIN: res_q.estimate <= qdi_pkg::sat_pos(tmp_q >>> S);
      default: begin
      end
    endcase
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result word is pending");

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> issued_q)
    else $error("arithmetic unit finished without a pending request");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status != qdi_pkg::STS_OK) |-> (out_o.data.estimate == '0))
    else $error("error result carries a nonzero estimate");

  a_ret_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> in_i.ready)
    else $error("block not idle after a result word left");

endmodule
